/* design/framed_serial_receiver_validator_unit_defines.svh */
// Assertion macros used by the checker file of the framed serial receiver.
`ifndef FRAMED_SERIAL_RECEIVER_VALIDATOR_UNIT_DEFINES_SVH
`define FRAMED_SERIAL_RECEIVER_VALIDATOR_UNIT_DEFINES_SVH

// Property checked at every rising edge, ignored while the reset is held.
`define FRSV_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define FRSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/frsv_pkg.sv */
// Types and constants of the framed serial receiver and validator.
package frsv_pkg;

    // Result codes of one step.
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_FRAME    = 2'd1,
        EV_TIMEOUT  = 2'd2,
        EV_OVERFLOW = 2'd3
    } t_event;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEAD_BYTE     = 2'd0;
    localparam logic [1:0] REG_TAIL_BYTE     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0] HEAD_BYTE_RST     = 8'h5A;
    localparam logic [7:0] TAIL_BYTE_RST     = 8'hAA;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd5;

    // Fixed frame layout.
    localparam int unsigned OVERHEAD_LEN  = 13;
    localparam int unsigned PAYLOAD_START = 10;
    localparam int unsigned POS_SEQUENCE  = 5;
    localparam int unsigned POS_SUBSEQ_LO = 6;
    localparam int unsigned POS_SUBSEQ_HI = 7;
    localparam int unsigned POS_COMMAND   = 8;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [10:0] frame_length;
        logic [4:0]  command_code;
        logic        write_request;
        logic [7:0]  sequence_res;
        logic [15:0] subsequence;
        logic        payload_valid;
        logic [9:0]  payload_index;
        logic [7:0]  payload_byte;
    } t_out_word;

    // Frame state that a clear sets back to zero (position is kept apart).
    typedef struct packed {
        logic        head_seen;
        logic [15:0] declared_length;
        logic [15:0] running_sum;
        logic [15:0] received_checksum;
        logic [7:0]  command_byte;
        logic [7:0]  sequence_byte;
        logic [15:0] subsequence_word;
    } t_frame;

endpackage

/* design/frsv_cfg_regs.sv */
// Configuration registers of the framed serial receiver: head, tail and timeout.
module frsv_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_wdata,
    output frsv_pkg::t_cfg    o_cfg
);
    import frsv_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEAD_BYTE:     n_cfg.head_byte     = i_cfg_wdata;
                REG_TAIL_BYTE:     n_cfg.tail_byte     = i_cfg_wdata;
                REG_TIMEOUT_TICKS: n_cfg.timeout_ticks = i_cfg_wdata;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte     <= HEAD_BYTE_RST;
            r_cfg.tail_byte     <= TAIL_BYTE_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/framed_serial_receiver_validator_unit.sv */
// Top level of the framed serial receiver and validator.
//
//  Channel   Direction  Handshake                     Word
//  in        input      i_in_valid / o_in_ready       byte or tick (t_in_word)
//  out       output     o_out_valid / i_out_ready     one result per input word
//  cfg       input      i_cfg_we, i_cfg_index         8-bit register write
//
// Every input word is handled by combinational logic; its result is registered and
// shows on the output in the cycle after the word is accepted.
// A new word is accepted in every cycle in which the result register is empty
// or its word is being taken: one word per cycle while the output is not stalled.
// A stalled output holds the input off; no receiver state changes while stalled.
// Reset is synchronous and active low; it restores the register defaults and
// empties the receiver and the byte timer.
module framed_serial_receiver_validator_unit #(
    parameter int unsigned MAX_FRAME_LEN = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  frsv_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output frsv_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_wdata
);
    import frsv_pkg::*;

    localparam int unsigned PW = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [16:0] MAX_LEN17  = 17'(MAX_FRAME_LEN);
    localparam logic [15:0] OVERHEAD16 = 16'(OVERHEAD_LEN);

    t_cfg       cfg;
    logic       in_fire;

    t_frame     r_frame;
    t_frame     n_frame;
    logic [PW-1:0] r_position;
    logic [PW-1:0] n_position;
    logic [7:0] r_byte_timer;
    logic [7:0] n_byte_timer;
    t_out_word  r_out;
    t_out_word  n_out;
    logic       r_out_valid;

    frsv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        logic [7:0]  b;
        logic [16:0] pos17;
        logic [15:0] len_m3;
        logic [16:0] pay_idx;

        n_frame      = r_frame;
        n_position   = r_position;
        n_byte_timer = r_byte_timer;
        n_out        = '0;
        b            = i_in_word.rx_byte;
        pos17        = '0;
        len_m3       = '0;
        pay_idx      = '0;

        if (i_in_word.req_type == REQ_TICK) begin
            if (r_byte_timer != 8'd0) begin
                n_byte_timer = r_byte_timer - 8'd1;
                if (r_byte_timer == 8'd1) begin
                    n_frame         = '0;
                    n_position      = '0;
                    n_out.event_res = EV_TIMEOUT;
                end
            end
        end else begin
            // A byte beyond the largest frame drops the partial frame first.
            if (17'(r_position) >= MAX_LEN17) begin
                n_frame         = '0;
                n_position      = '0;
                n_out.event_res = EV_OVERFLOW;
            end
            if (!n_frame.head_seen) begin
                n_position = '0;
            end

            pos17  = 17'(n_position);
            len_m3 = n_frame.declared_length - 16'd3;
            if (pos17 == 17'd0) begin
                n_frame.running_sum = {8'd0, b};
            end else if (pos17 < 17'd3) begin
                n_frame.running_sum = n_frame.running_sum + {8'd0, b};
                if (pos17 == 17'd1) begin
                    n_frame.declared_length[7:0] = b;
                end else begin
                    n_frame.declared_length[15:8] = b;
                end
            end else if (n_frame.declared_length >= OVERHEAD16) begin
                if (pos17 < {1'b0, len_m3}) begin
                    n_frame.running_sum = n_frame.running_sum + {8'd0, b};
                end else if (pos17 == {1'b0, len_m3}) begin
                    n_frame.received_checksum[7:0] = b;
                end else if (pos17 == {1'b0, len_m3} + 17'd1) begin
                    n_frame.received_checksum[15:8] = b;
                end
                if (pos17 >= 17'(PAYLOAD_START) && pos17 < {1'b0, len_m3}) begin
                    pay_idx             = pos17 - 17'(PAYLOAD_START);
                    n_out.payload_valid = 1'b1;
                    n_out.payload_index = pay_idx[9:0];
                    n_out.payload_byte  = b;
                end
            end

            if (pos17 == 17'(POS_SEQUENCE)) begin
                n_frame.sequence_byte = b;
            end else if (pos17 == 17'(POS_SUBSEQ_LO)) begin
                n_frame.subsequence_word[7:0] = b;
            end else if (pos17 == 17'(POS_SUBSEQ_HI)) begin
                n_frame.subsequence_word[15:8] = b;
            end else if (pos17 == 17'(POS_COMMAND)) begin
                n_frame.command_byte = b;
            end

            // The position is below the limit here, so the increment fits.
            n_position   = n_position + PW'(1);
            n_byte_timer = cfg.timeout_ticks;
            if (b == cfg.head_byte) begin
                n_frame.head_seen = 1'b1;
            end

            if (n_frame.head_seen && n_frame.declared_length >= OVERHEAD16 &&
                17'(n_position) == {1'b0, n_frame.declared_length} &&
                b == cfg.tail_byte &&
                n_frame.running_sum == n_frame.received_checksum) begin
                n_out.event_res     = EV_FRAME;
                n_out.frame_length  = n_frame.declared_length[10:0];
                n_out.command_code  = n_frame.command_byte[4:0];
                n_out.write_request = n_frame.command_byte[5];
                n_out.sequence_res  = n_frame.sequence_byte;
                n_out.subsequence   = n_frame.subsequence_word;
                n_frame             = '0;
                n_position          = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame      <= '0;
            r_position   <= '0;
            r_byte_timer <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_frame      <= n_frame;
                r_position   <= n_position;
                r_byte_timer <= n_byte_timer;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* design/frsv_checker.sv */
// Port-level checker of the framed serial receiver, bound to the top level.
`include "framed_serial_receiver_validator_unit_defines.svh"

module frsv_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  frsv_pkg::t_out_word  o_out_word
);
    import frsv_pkg::*;

    // A waiting result word is held until it is taken.
    `FRSV_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word), "result word dropped or changed while stalled")

    // Frame fields are zero unless a valid frame is reported.
    `FRSV_ASSERT_RST(a_frame_fields, i_clk, i_rst_n, o_out_valid && o_out_word.event_res != EV_FRAME |-> o_out_word.frame_length == 11'd0 && o_out_word.command_code == 5'd0 && !o_out_word.write_request && o_out_word.sequence_res == 8'd0 && o_out_word.subsequence == 16'd0, "frame fields set without a valid frame")

    // A reported frame never has a length below the fixed overhead.
    `FRSV_ASSERT_RST(a_frame_len, i_clk, i_rst_n, o_out_valid && o_out_word.event_res == EV_FRAME |-> o_out_word.frame_length >= 11'(OVERHEAD_LEN), "valid frame shorter than overhead")

    // Payload bytes never come with a frame end, timeout or overflow.
    `FRSV_ASSERT_RST(a_payload_quiet, i_clk, i_rst_n, o_out_valid && o_out_word.payload_valid |-> o_out_word.event_res == EV_NONE, "payload byte reported with an event")

    // The output is empty in the cycle after a reset edge.
    `FRSV_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

endmodule

bind framed_serial_receiver_validator_unit frsv_checker u_frsv_checker (.*);

/* sim/framed_serial_receiver_validator_unit_tb.sv */
// Self-checking testbench of the framed serial receiver: frames, noise, ticks and stalls.
`timescale 1ns / 1ps

module framed_serial_receiver_validator_unit_tb;
    import frsv_pkg::*;

    localparam int unsigned MAX_FRAME_LEN = 1024;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned PHASE_WORDS   = 20;

    typedef enum {FLAW_NONE, FLAW_SUM, FLAW_TAIL, FLAW_CUT} t_flaw;

    // Shadow copy of the receiver: it follows every accepted word and keeps
    // the result words that the block still owes.
    class frame_receiver_shadow;
        t_cfg        cfg;
        t_frame      frame;
        int unsigned position;
        logic [7:0]  byte_timer;
        int unsigned max_len;
        int unsigned errors;
        t_out_word   owed_results[$];

        function new(int unsigned frame_limit);
            max_len            = frame_limit;
            cfg.head_byte      = HEAD_BYTE_RST;
            cfg.tail_byte      = TAIL_BYTE_RST;
            cfg.timeout_ticks  = TIMEOUT_TICKS_RST;
            frame              = '0;
            position           = 0;
            byte_timer         = '0;
            errors             = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [7:0] value);
            case (index)
                REG_HEAD_BYTE:     cfg.head_byte = value;
                REG_TAIL_BYTE:     cfg.tail_byte = value;
                REG_TIMEOUT_TICKS: cfg.timeout_ticks = value;
                default: ;
            endcase
        endfunction

        function void clear_frame();
            frame    = '0;
            position = 0;
        endfunction

        function void receive_word(t_in_word w);
            t_out_word   r;
            logic [7:0]  b;
            int unsigned p;
            int unsigned len;
            r = '0;
            b = w.rx_byte;
            if (w.req_type == REQ_TICK) begin
                if (byte_timer != 0) begin
                    byte_timer = byte_timer - 8'd1;
                    if (byte_timer == 0) begin
                        clear_frame();
                        r.event_res = EV_TIMEOUT;
                    end
                end
            end else begin
                if (position >= max_len) begin
                    clear_frame();
                    r.event_res = EV_OVERFLOW;
                end
                if (!frame.head_seen) position = 0;
                p   = position;
                len = frame.declared_length;
                if (p == 0) begin
                    frame.running_sum = 16'(b);
                end else if (p < 3) begin
                    frame.running_sum = frame.running_sum + 16'(b);
                    if (p == 1) frame.declared_length[7:0] = b;
                    else frame.declared_length[15:8] = b;
                end else if (len >= OVERHEAD_LEN) begin
                    if (p < len - 3) frame.running_sum = frame.running_sum + 16'(b);
                    else if (p == len - 3) frame.received_checksum[7:0] = b;
                    else if (p == len - 2) frame.received_checksum[15:8] = b;
                    if (p >= PAYLOAD_START && p < len - 3) begin
                        r.payload_valid = 1'b1;
                        r.payload_index = 10'(p - PAYLOAD_START);
                        r.payload_byte  = b;
                    end
                end
                if (p == POS_SEQUENCE) frame.sequence_byte = b;
                else if (p == POS_SUBSEQ_LO) frame.subsequence_word[7:0] = b;
                else if (p == POS_SUBSEQ_HI) frame.subsequence_word[15:8] = b;
                else if (p == POS_COMMAND) frame.command_byte = b;
                position   = p + 1;
                byte_timer = cfg.timeout_ticks;
                if (b == cfg.head_byte) frame.head_seen = 1'b1;
                len = frame.declared_length;
                if (frame.head_seen && len >= OVERHEAD_LEN && position == len &&
                    b == cfg.tail_byte && frame.running_sum == frame.received_checksum) begin
                    r.event_res     = EV_FRAME;
                    r.frame_length  = 11'(len);
                    r.command_code  = frame.command_byte[4:0];
                    r.write_request = frame.command_byte[5];
                    r.sequence_res  = frame.sequence_byte;
                    r.subsequence   = frame.subsequence_word;
                    clear_frame();
                end
            end
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (owed_results.size() == 0) begin
                $error("result word %h arrived with nothing owed", got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("command_code", want.command_code, got.command_code);
            compare_field("write_request", want.write_request, got.write_request);
            compare_field("sequence_res", want.sequence_res, got.sequence_res);
            compare_field("subsequence", want.subsequence, got.subsequence);
            compare_field("payload_valid", want.payload_valid, got.payload_valid);
            compare_field("payload_index", want.payload_index, got.payload_index);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_word;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_HEAD_BYTE;
    logic [7:0]  i_cfg_wdata = '0;

    frame_receiver_shadow shadow = new(MAX_FRAME_LEN);

    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_due = 1'b0;
    bit          calm = 1'b0;

    framed_serial_receiver_validator_unit #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check every taken word, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) shadow.check_word(o_out_word);
        if (hold_due) begin
            hold_due  = 1'b0;
            hold_left = 300;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 28);
        end
    end

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 28) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shadow.receive_word(w);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_word w;
        w.req_type = REQ_BYTE;
        w.rx_byte  = b;
        send_word(w);
    endtask

    task automatic send_tick();
        t_in_word w;
        w.req_type = REQ_TICK;
        w.rx_byte  = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task automatic send_frame(input int unsigned len, input logic [7:0] seq,
                              input logic [15:0] sub, input logic [7:0] cmd,
                              input t_flaw flaw);
        logic [7:0]  frm[$];
        logic [15:0] frame_sum;
        logic [15:0] len16;
        int unsigned count;
        len16 = 16'(len);
        frm = {};
        frm.push_back(shadow.cfg.head_byte);
        frm.push_back(len16[7:0]);
        frm.push_back(len16[15:8]);
        frm.push_back(8'($urandom_range(0, 255)));
        frm.push_back(8'($urandom_range(0, 255)));
        frm.push_back(seq);
        frm.push_back(sub[7:0]);
        frm.push_back(sub[15:8]);
        frm.push_back(cmd);
        frm.push_back(8'($urandom_range(0, 255)));
        while (frm.size() < len - 3) frm.push_back(8'($urandom_range(0, 255)));
        // The checksum covers every byte from the head up to the last payload byte.
        frame_sum = '0;
        foreach (frm[k]) frame_sum = frame_sum + 16'(frm[k]);
        if (flaw == FLAW_SUM) frame_sum = frame_sum ^ 16'(1 << $urandom_range(0, 15));
        frm.push_back(frame_sum[7:0]);
        frm.push_back(frame_sum[15:8]);
        if (flaw == FLAW_TAIL)
            frm.push_back(shadow.cfg.tail_byte ^ 8'($urandom_range(1, 255)));
        else
            frm.push_back(shadow.cfg.tail_byte);
        count = (flaw == FLAW_CUT) ? $urandom_range(3, len - 1) : len;
        for (int unsigned i = 0; i < count; i++) begin
            // A single tick between bytes must not drop the frame.
            if (shadow.cfg.timeout_ticks > 1 && $urandom_range(0, 99) < 3) send_tick();
            send_byte(frm[i]);
        end
    endtask

    task automatic send_odd_length(input logic [15:0] len, input int unsigned count);
        send_byte(shadow.cfg.head_byte);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Ticks until a frame left open by a broken sequence times out.
    task automatic drop_open_frame();
        while (shadow.cfg.timeout_ticks != 0 && shadow.frame.head_seen) send_tick();
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (shadow.owed_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] head, input logic [7:0] tail,
                              input logic [7:0] ticks);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_HEAD_BYTE;
        i_cfg_wdata <= head;
        @(posedge i_clk);
        i_cfg_index <= REG_TAIL_BYTE;
        i_cfg_wdata <= tail;
        @(posedge i_clk);
        i_cfg_index <= REG_TIMEOUT_TICKS;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow.set_register(REG_HEAD_BYTE, head);
        shadow.set_register(REG_TAIL_BYTE, tail);
        shadow.set_register(REG_TIMEOUT_TICKS, ticks);
    endtask

    initial begin
        int unsigned start;
        int unsigned sel;
        int unsigned len;
        int unsigned n;
        logic [7:0]  b;
        bit          no_timeout;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tick on an idle timer, smallest frame with all fields at
        // their top values, a timeout of a lone byte, then an idle tick again.
        send_tick();
        send_frame(OVERHEAD_LEN, 8'hFF, 16'hFFFF, 8'hFF, FLAW_NONE);
        send_byte(8'h00);
        repeat (5) send_tick();
        send_tick();
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(HEAD_BYTE_RST, TAIL_BYTE_RST, TIMEOUT_TICKS_RST);
                1: set_config(8'h00, 8'hFF, 8'd1);
                2: set_config(8'hFF, 8'h00, 8'd255);
                3: set_config(8'h3C, 8'hC3, 8'd0);
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(2, 12)));
            endcase
            no_timeout = (shadow.cfg.timeout_ticks == 0);
            if (phase == 0) begin
                // The longest declared length with a bad checksum streams in with no
                // idling while the receiver first holds off; the next byte overflows.
                calm     = 1'b1;
                hold_due = 1'b1;
                send_frame(MAX_FRAME_LEN, 8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                           FLAW_SUM);
                calm = 1'b0;
                b = shadow.cfg.head_byte ^ 8'h01;
                send_byte(b);
                drop_open_frame();
            end
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                calm = (phase == 1 && words_sent - start < 100);
                sel = $urandom_range(0, 99);
                // Without a timeout an open frame never closes, so keep to clean traffic.
                if (no_timeout && sel >= 60 && sel < 82) sel = 0;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(13, 40);
                if (sel < 60) begin
                    send_frame(len, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), FLAW_NONE);
                end else if (sel < 72) begin
                    send_frame(len, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)), t_flaw'($urandom_range(1, 3)));
                end else if (sel < 82) begin
                    if ($urandom_range(0, 1) == 0)
                        send_odd_length(16'($urandom_range(0, OVERHEAD_LEN - 1)),
                                        $urandom_range(2, 20));
                    else
                        send_odd_length(16'($urandom_range(MAX_FRAME_LEN + 1, 65535)),
                                        $urandom_range(2, 20));
                end else if (sel < 90) begin
                    repeat ($urandom_range(1, 5)) begin
                        b = 8'($urandom_range(0, 255));
                        while (no_timeout && b == shadow.cfg.head_byte)
                            b = 8'($urandom_range(0, 255));
                        send_byte(b);
                    end
                end else begin
                    n = $urandom_range(1, 4);
                    if ($urandom_range(0, 9) < 3 && !no_timeout) n = shadow.cfg.timeout_ticks;
                    repeat (n) send_tick();
                end
                drop_open_frame();
            end
            calm = 1'b0;
            settle();
        end

        repeat (4) @(posedge i_clk);
        if (shadow.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
